@@ design/assert_macros.svh @@
// Assertion helpers for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/psc_pkg.sv @@
package psc_pkg;

  // Result format: signed Q1.15 with a 16-bit magnitude search.
  localparam int CORR_W    = 16;
  localparam int FRAC_BITS = 15;
  localparam int QMAG_W    = 16;
  localparam int QIDX_W    = 4;
  localparam int RHS_SHIFT = 2 * FRAC_BITS;
  localparam logic [CORR_W-1:0] CORR_MAX = 16'h7FFF;

  // Queue between the accumulator and the solver.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } psc_q_status_t;

  // Solver sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_MUL_GO   = 7'b0000010,
    ST_MUL_WAIT = 7'b0000100,
    ST_SQ_A     = 7'b0001000,
    ST_SQ_B     = 7'b0010000,
    ST_SQ_C     = 7'b0100000,
    ST_OUT      = 7'b1000000
  } psc_state_t;

  // Products taken on the shared multiplier, in order.
  typedef enum logic [2:0] {
    MS_NXX  = 3'd0,
    MS_SXSX = 3'd1,
    MS_NYY  = 3'd2,
    MS_SYSY = 3'd3,
    MS_NXY  = 3'd4,
    MS_SXSY = 3'd5,
    MS_COV2 = 3'd6,
    MS_VV   = 3'd7
  } psc_mstep_t;

endpackage

@@ design/psc_mul.sv @@
module psc_mul #(
  parameter int AW = 57,
  parameter int BW = 57
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic               done,
  output logic [AW+BW-1:0]   prod
);
  localparam int PW = AW + BW;

  logic          busy_r, busy_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [PW-1:0] ma_r, ma_nxt;
  logic [BW-1:0] mb_r, mb_nxt;

  // Shift-add: one multiplier bit per cycle, stops once no bits remain.
  always_comb begin
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    if (start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      ma_nxt   = PW'(a);
      mb_nxt   = b;
    end else if (busy_r) begin
      if (mb_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (mb_r[0]) acc_nxt = acc_r + ma_r;
        ma_nxt = ma_r << 1;
        mb_nxt = mb_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    acc_r <= acc_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
  end

  assign done = busy_r && (mb_r == '0);
  assign prod = acc_r;
endmodule

@@ design/psc_front.sv @@
module psc_front #(
  parameter int MAX_PAIRS = 4096,
  parameter int SW        = 16,
  parameter int CW        = 13,
  parameter int S1W       = 28,
  parameter int S2W       = 44,
  parameter int SNAP_W    = 1 + CW + 3 * S2W + 2 * S1W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SW-1:0]          in_sample_x,
  input  logic [SW-1:0]          in_sample_y,
  input  logic                   in_last_pair,
  input  psc_pkg::psc_q_status_t q_status,
  output logic                   push,
  output logic [SNAP_W-1:0]      push_data
);
  import psc_pkg::*;

  logic [S1W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [S2W-1:0] sxx_r, sxx_nxt, syy_r, syy_nxt, sxy_r, sxy_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic           ovf_r, ovf_nxt;
  logic           take;
  logic           room;

  assign in_ready = !q_status.full;
  assign take     = in_valid && in_ready;
  assign room     = n_r < CW'(MAX_PAIRS);

  // Accumulate one pair per transaction; pairs past the limit only set the flag.
  always_comb begin
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sxx_nxt = sxx_r;
    syy_nxt = syy_r;
    sxy_nxt = sxy_r;
    n_nxt   = n_r;
    ovf_nxt = ovf_r;
    if (take) begin
      if (room) begin
        sx_nxt  = sx_r + S1W'(in_sample_x);
        sy_nxt  = sy_r + S1W'(in_sample_y);
        sxx_nxt = sxx_r + S2W'(in_sample_x * in_sample_x);
        syy_nxt = syy_r + S2W'(in_sample_y * in_sample_y);
        sxy_nxt = sxy_r + S2W'(in_sample_x * in_sample_y);
        n_nxt   = n_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // The final pair hands the finished sums to the queue.
  assign push      = take && in_last_pair;
  assign push_data = {ovf_nxt, n_nxt, sxy_nxt, syy_nxt, sxx_nxt, sy_nxt, sx_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
      n_r   <= '0;
      ovf_r <= 1'b0;
    end else begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sxx_r <= sxx_nxt;
      syy_r <= syy_nxt;
      sxy_r <= sxy_nxt;
      n_r   <= n_nxt;
      ovf_r <= ovf_nxt;
    end
  end
endmodule

@@ design/psc_queue.sv @@
module psc_queue #(
  parameter int W = 186
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [W-1:0]           push_data,
  input  logic                   pop,
  output logic [W-1:0]           pop_data,
  output psc_pkg::psc_q_status_t status
);
  import psc_pkg::*;

  logic [W-1:0]      slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign status.full  = count_r == QCNT_W'(QUEUE_DEPTH);
  assign status.empty = count_r == '0;
  assign pop_data     = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
    if (push) slot_r[wr_ptr_r] <= push_data;
  end
endmodule

@@ design/psc_back.sv @@
module psc_back #(
  parameter int CW     = 13,
  parameter int S1W    = 28,
  parameter int S2W    = 44,
  parameter int SNAP_W = 1 + CW + 3 * S2W + 2 * S1W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  psc_pkg::psc_q_status_t q_status,
  input  logic [SNAP_W-1:0]      pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     out_correlation,
  output logic                   out_zero_denominator,
  output logic [CW-1:0]          out_pair_count,
  output logic                   out_count_overflow
);
  import psc_pkg::*;

  localparam int VW = CW + S2W;
  localparam int PW = 2 * VW;
  localparam int RW = PW + RHS_SHIFT;
  localparam int TW = RW + 2;

  psc_state_t state_r, state_nxt;
  psc_mstep_t step_r, step_nxt;

  logic [S1W-1:0] sx_r, sy_r;
  logic [S2W-1:0] sxx_r, syy_r, sxy_r;
  logic [CW-1:0]  n_r;
  logic           ovf_r;

  logic [VW-1:0] t_r, t_nxt, vx_r, vx_nxt, vy_r, vy_nxt, cmag_r, cmag_nxt;
  logic          neg_r, neg_nxt;
  logic [RW-1:0] rhs_r, rhs_nxt, p_r, p_nxt, qa_r, qa_nxt;
  logic [PW-1:0] vv_r, vv_nxt;
  logic [TW-1:0] tsq_r, tsq_nxt;
  logic [QMAG_W-1:0] q_r, q_nxt;
  logic [QIDX_W-1:0] k_r, k_nxt;
  logic [CORR_W-1:0] corr_r, corr_nxt;
  logic          zden_r, zden_nxt;

  logic          mul_start, mul_done;
  logic [VW-1:0] mul_a, mul_b, pv;
  logic [PW-1:0] mul_prod;

  assign pop = (state_r == ST_IDLE) && !q_status.empty;

  // Operands for each step of the product sequence.
  always_comb begin
    unique case (step_r)
      MS_NXX:  begin mul_a = VW'(sxx_r);  mul_b = VW'(n_r);  end
      MS_SXSX: begin mul_a = VW'(sx_r);   mul_b = VW'(sx_r); end
      MS_NYY:  begin mul_a = VW'(syy_r);  mul_b = VW'(n_r);  end
      MS_SYSY: begin mul_a = VW'(sy_r);   mul_b = VW'(sy_r); end
      MS_NXY:  begin mul_a = VW'(sxy_r);  mul_b = VW'(n_r);  end
      MS_SXSY: begin mul_a = VW'(sx_r);   mul_b = VW'(sy_r); end
      MS_COV2: begin mul_a = cmag_r;      mul_b = cmag_r;    end
      MS_VV:   begin mul_a = vx_r;        mul_b = vy_r;      end
      default: begin mul_a = '0;          mul_b = '0;        end
    endcase
  end

  assign mul_start = state_r == ST_MUL_GO;
  assign pv        = mul_prod[VW-1:0];

  psc_mul #(.AW(VW), .BW(VW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Sequencer: products first, then, unless a variance is zero, a bitwise magnitude search from the top bit down.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    t_nxt     = t_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    cmag_nxt  = cmag_r;
    neg_nxt   = neg_r;
    rhs_nxt   = rhs_r;
    vv_nxt    = vv_r;
    p_nxt     = p_r;
    qa_nxt    = qa_r;
    tsq_nxt   = tsq_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    corr_nxt  = corr_r;
    zden_nxt  = zden_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = ST_MUL_GO;
          step_nxt  = MS_NXX;
        end
      end
      ST_MUL_GO: begin
        state_nxt = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          state_nxt = ST_MUL_GO;
          step_nxt  = psc_mstep_t'(step_r + 3'd1);
          unique case (step_r)
            MS_NXX, MS_NYY, MS_NXY: t_nxt = pv;
            MS_SXSX: vx_nxt = (t_r > pv) ? t_r - pv : '0;
            MS_SYSY: vy_nxt = (t_r > pv) ? t_r - pv : '0;
            MS_SXSY: begin
              neg_nxt  = pv > t_r;
              cmag_nxt = (pv > t_r) ? pv - t_r : t_r - pv;
              if (vx_r == '0 || vy_r == '0) begin
                zden_nxt  = 1'b1;
                corr_nxt  = '0;
                state_nxt = ST_OUT;
              end
            end
            MS_COV2: rhs_nxt = RW'(mul_prod) << RHS_SHIFT;
            MS_VV: begin
              vv_nxt    = mul_prod;
              p_nxt     = '0;
              qa_nxt    = '0;
              q_nxt     = '0;
              k_nxt     = QIDX_W'(QMAG_W - 1);
              zden_nxt  = 1'b0;
              state_nxt = ST_SQ_A;
            end
            default: ;
          endcase
        end
      end
      ST_SQ_A: begin
        // Trial square (q + 2^k)^2 * vv, first adding 2^2k * vv.
        tsq_nxt   = TW'(p_r) + (TW'(vv_r) << {k_r, 1'b0});
        state_nxt = ST_SQ_B;
      end
      ST_SQ_B: begin
        tsq_nxt   = tsq_r + (TW'(qa_r) << ({1'b0, k_r} + 5'd1));
        state_nxt = ST_SQ_C;
      end
      ST_SQ_C: begin
        if (tsq_r <= TW'(rhs_r)) begin
          p_nxt  = tsq_r[RW-1:0];
          qa_nxt = qa_r + (RW'(vv_r) << k_r);
          q_nxt  = q_r | (QMAG_W'(1) << k_r);
        end
        if (k_r == '0) begin
          state_nxt = ST_OUT;
          if (neg_r) corr_nxt = CORR_W'(0) - q_nxt;
          else corr_nxt = q_nxt[QMAG_W-1] ? CORR_MAX : q_nxt;
        end else begin
          k_nxt     = k_r - QIDX_W'(1);
          state_nxt = ST_SQ_A;
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= MS_NXX;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    if (pop) begin
      {ovf_r, n_r, sxy_r, syy_r, sxx_r, sy_r, sx_r} <= pop_data;
    end
    t_r    <= t_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    cmag_r <= cmag_nxt;
    neg_r  <= neg_nxt;
    rhs_r  <= rhs_nxt;
    vv_r   <= vv_nxt;
    p_r    <= p_nxt;
    qa_r   <= qa_nxt;
    tsq_r  <= tsq_nxt;
    q_r    <= q_nxt;
    k_r    <= k_nxt;
    corr_r <= corr_nxt;
    zden_r <= zden_nxt;
  end

  assign out_valid            = state_r == ST_OUT;
  assign out_correlation      = corr_r;
  assign out_zero_denominator = zden_r;
  assign out_pair_count       = n_r;
  assign out_count_overflow   = ovf_r;
endmodule

@@ design/pearson_correlation_unit.sv @@
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_sample_x, in_sample_y, in_last_pair
// out     | output    | out_valid / out_ready| out_correlation, out_zero_denominator,
//         |           |                      | out_pair_count, out_count_overflow
//
// The accumulator takes one pair per cycle while the two-entry queue has room.
// A final pair queues the sums. The solver then runs 8 shift-add products, stopping
// after the sixth when a variance is zero, and otherwise ends with a bitwise
// magnitude search from the top bit down.
// The shared bit-serial multiplier sets the solver latency.
// Reset is synchronous and active low; it clears sums, queue and sequencer.
// A result waiting on out_ready stalls the solver; the accumulator goes on until the queue fills.
`include "assert_macros.svh"

module pearson_correlation_unit #(
  parameter int MAX_PAIRS   = 4096,
  parameter int SAMPLE_BITS = 16,
  localparam int CW         = $clog2(MAX_PAIRS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample_x,
  input  logic [SAMPLE_BITS-1:0] in_sample_y,
  input  logic                   in_last_pair,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     out_correlation,
  output logic                   out_zero_denominator,
  output logic [CW-1:0]          out_pair_count,
  output logic                   out_count_overflow
);
  import psc_pkg::*;

  localparam int S1W    = SAMPLE_BITS + $clog2(MAX_PAIRS);
  localparam int S2W    = 2 * SAMPLE_BITS + $clog2(MAX_PAIRS);
  localparam int SNAP_W = 1 + CW + 3 * S2W + 2 * S1W;

  psc_q_status_t     q_status;
  logic              push, pop;
  logic [SNAP_W-1:0] push_data, pop_data;
  logic              zden_out, ovf_out, one_out, held_out;

  psc_front #(
    .MAX_PAIRS (MAX_PAIRS),
    .SW        (SAMPLE_BITS),
    .CW        (CW),
    .S1W       (S1W),
    .S2W       (S2W),
    .SNAP_W    (SNAP_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_x  (in_sample_x),
    .in_sample_y  (in_sample_y),
    .in_last_pair (in_last_pair),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  psc_queue #(.W(SNAP_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  psc_back #(
    .CW     (CW),
    .S1W    (S1W),
    .S2W    (S2W),
    .SNAP_W (SNAP_W)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_status             (q_status),
    .pop_data             (pop_data),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_correlation      (out_correlation),
    .out_zero_denominator (out_zero_denominator),
    .out_pair_count       (out_pair_count),
    .out_count_overflow   (out_count_overflow)
  );

  // Qualified result conditions used by the checks below.
  assign zden_out = out_valid && out_zero_denominator;
  assign ovf_out  = out_valid && out_count_overflow;
  assign one_out  = out_valid && (out_pair_count == CW'(1));
  assign held_out = out_valid && !out_ready;

  // A zero variance always forces a zero coefficient.
  `PSC_ASSERT_IMPL(a_zden_zero, zden_out, out_correlation == 16'sd0, "zero variance, nonzero result")
  // Dropped pairs only happen once the count is full.
  `PSC_ASSERT_IMPL(a_ovf_full, ovf_out, out_pair_count == CW'(MAX_PAIRS), "overflow below limit")
  // A single pair has no variance.
  `PSC_ASSERT_IMPL(a_one_pair, one_out, out_zero_denominator, "single pair with variance")
  // A held result keeps its value until the transaction completes.
  `PSC_ASSERT_NEXT(a_hold, held_out, out_valid && $stable(out_correlation), "stalled result changed")

endmodule
